>>> rtl/tta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types and constants of the triangle tangent accumulator.
// ----------------------------------------------------------------------------
package tta_pkg;

	localparam int IDX_W = 10;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_TRI   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DEGEN  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NOP,
		OP_WRITE,
		OP_RD_A,
		OP_RD_B,
		OP_RD_C,
		OP_LAT_C,
		OP_MUL,
		OP_DET,
		OP_NUM,
		OP_DIV_START,
		OP_STORE_Q,
		OP_ACC_RD,
		OP_ACC_WR,
		OP_RD_SUMS,
		OP_LAT_SUMS
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] sel;   // component or corner select
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_busy;
	} sts_t;

endpackage : tta_pkg
`default_nettype wire

>>> rtl/tta_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tta_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule : tta_ram
`default_nettype wire

>>> rtl/tta_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tta_div
// Radix-2 restoring divider: signed (num * 2^12) / den, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tta_div (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire signed [63:0] num,
	input  wire signed [35:0] den,
	output logic              busy,
	output logic signed [31:0] quot
);
	localparam int NW = 76; // |num|*2^12 fits in 76 bits

	logic [NW-1:0] n_q;
	logic [35:0]   d_q;
	logic [36:0]   r_q;
	logic [6:0]    cnt_q;
	logic          neg_q;
	logic [63:0]   nmag;
	logic [35:0]   dmag;
	logic [36:0]   r_sh;
	logic [36:0]   r_sub;
	logic [NW:0]   q_full;
	logic [32:0]   mag;

	assign nmag  = num[63] ? 64'(-num) : 64'(num);
	assign dmag  = den[35] ? 36'(-den) : 36'(den);
	assign r_sh  = {r_q[35:0], n_q[NW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= 7'(NW);
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				busy <= 1'b0;
		end
	end

	// quotient bits shift into n_q as numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {nmag, 12'd0};
			d_q   <= dmag;
			r_q   <= '0;
			neg_q <= num[63] ^ den[35];
		end else if (busy) begin
			if (!r_sub[36]) begin
				r_q <= r_sub;
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign q_full = {1'b0, n_q};
	assign mag = (|q_full[NW:32]) ? 33'h1_0000_0000 : {1'b0, q_full[31:0]};

	always_comb begin
		if (neg_q)
			quot = (mag >= 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag);
		else
			quot = (mag >= 33'h0_8000_0000) ? 32'sh7fff_ffff : 32'(mag);
	end
endmodule : tta_div
`default_nettype wire

>>> rtl/tta_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tta_datapath
// Vertex memories, delta and determinant arithmetic, divider and sum update.
// ----------------------------------------------------------------------------
module tta_datapath #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire tta_pkg::cmd_t  cmd,
	output tta_pkg::sts_t       sts,
	input  wire [9:0]           idx_a,
	input  wire [9:0]           idx_b,
	input  wire [9:0]           idx_c,
	input  wire signed [31:0]   pos_x,
	input  wire signed [31:0]   pos_y,
	input  wire signed [31:0]   pos_z,
	input  wire signed [15:0]   tex_u,
	input  wire signed [15:0]   tex_v,
	output logic [191:0]        sums
);
	import tta_pkg::*;

	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

	logic          we_pos, we_tan, we_bit;
	logic [AW-1:0] addr_v, addr_s;
	logic [127:0]  vtx_wd, vtx_rd;
	logic [95:0]   tan_wd, tan_rd, bit_wd, bit_rd;

	logic signed [31:0] pa_q [3];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [15:0] ua_q, va_q;
	logic signed [16:0] s1_q, s2_q, t1_q, t2_q;
	logic signed [33:0] m1_q, m2_q;
	logic signed [35:0] det_q;
	logic signed [50:0] p1_q, p2_q;
	logic signed [63:0] num_next;
	logic signed [31:0] sdir_q [3];
	logic signed [31:0] tdir_q [3];
	logic signed [31:0] quot;
	logic               div_busy;
	logic [2:0]         sel;
	logic [191:0]       sums_q;

	assign sel = cmd.sel;

	// numerator goes straight to the divider so it is current at the start command
	assign num_next = 64'(p1_q) - 64'(p2_q);

	tta_ram #(.WIDTH(128), .DEPTH(VERTEX_DEPTH)) u_vtx (
		.clk(clk), .we(we_pos), .addr(addr_v), .wdata(vtx_wd), .rdata(vtx_rd));
	tta_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_tan (
		.clk(clk), .we(we_tan), .addr(addr_s), .wdata(tan_wd), .rdata(tan_rd));
	tta_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_bit (
		.clk(clk), .we(we_bit), .addr(addr_s), .wdata(bit_wd), .rdata(bit_rd));

	tta_div u_div (.clk(clk), .arst_n(arst_n), .start(cmd.op == OP_DIV_START),
		.num(num_next), .den(det_q), .busy(div_busy), .quot(quot));

	assign sts.det_zero = (det_q == '0);
	assign sts.div_busy = div_busy;
	assign sums = sums_q;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return s[31:0];
	endfunction

	always_comb begin
		logic [9:0] vi;
		logic [9:0] si;
		case (sel[1:0])
			2'd1:    vi = idx_b;
			2'd2:    vi = idx_c;
			default: vi = idx_a;
		endcase
		si = vi;
		case (cmd.op)
			OP_RD_A:  vi = idx_a;
			OP_RD_B:  vi = idx_b;
			OP_RD_C:  vi = idx_c;
			default:  ;
		endcase
		addr_v = AW'(vi);
		addr_s = AW'(si);
		we_pos = (cmd.op == OP_WRITE);
		vtx_wd = {tex_v, tex_u, pos_z, pos_y, pos_x};
		we_tan = (cmd.op == OP_WRITE) || (cmd.op == OP_ACC_WR);
		we_bit = we_tan;
		if (cmd.op == OP_WRITE) begin
			tan_wd = '0;
			bit_wd = '0;
		end else begin
			tan_wd = {sat_add(tan_rd[95:64], sdir_q[2]), sat_add(tan_rd[63:32], sdir_q[1]),
				sat_add(tan_rd[31:0], sdir_q[0])};
			bit_wd = {sat_add(bit_rd[95:64], tdir_q[2]), sat_add(bit_rd[63:32], tdir_q[1]),
				sat_add(bit_rd[31:0], tdir_q[0])};
		end
	end

	// RD_A issued, data arrives during RD_B; B arrives during RD_C; C at LAT_C
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RD_B: begin
				pa_q[0] <= vtx_rd[31:0];
				pa_q[1] <= vtx_rd[63:32];
				pa_q[2] <= vtx_rd[95:64];
				ua_q    <= vtx_rd[111:96];
				va_q    <= vtx_rd[127:112];
			end
			OP_RD_C: begin
				e1_q[0] <= 33'(signed'(vtx_rd[31:0])) - 33'(pa_q[0]);
				e1_q[1] <= 33'(signed'(vtx_rd[63:32])) - 33'(pa_q[1]);
				e1_q[2] <= 33'(signed'(vtx_rd[95:64])) - 33'(pa_q[2]);
				s1_q    <= 17'(signed'(vtx_rd[111:96])) - 17'(ua_q);
				t1_q    <= 17'(signed'(vtx_rd[127:112])) - 17'(va_q);
			end
			OP_LAT_C: begin
				e2_q[0] <= 33'(signed'(vtx_rd[31:0])) - 33'(pa_q[0]);
				e2_q[1] <= 33'(signed'(vtx_rd[63:32])) - 33'(pa_q[1]);
				e2_q[2] <= 33'(signed'(vtx_rd[95:64])) - 33'(pa_q[2]);
				s2_q    <= 17'(signed'(vtx_rd[111:96])) - 17'(ua_q);
				t2_q    <= 17'(signed'(vtx_rd[127:112])) - 17'(va_q);
			end
			OP_MUL: begin
				m1_q <= s1_q * t2_q;
				m2_q <= s2_q * t1_q;
			end
			OP_DET: det_q <= 36'(m1_q) - 36'(m2_q);
			OP_NUM: begin
				// sel[2]: bitangent direction, sel[1:0]: component
				if (!sel[2]) begin
					p1_q <= t2_q * e1_q[sel[1:0]];
					p2_q <= t1_q * e2_q[sel[1:0]];
				end else begin
					p1_q <= s1_q * e2_q[sel[1:0]];
					p2_q <= s2_q * e1_q[sel[1:0]];
				end
			end
			default: ;
		endcase
	end

	// sel marks the slot of the finished quotient: component plus one
	always_ff @(posedge clk) begin
		if (cmd.op == OP_STORE_Q) begin
			if (!sel[2]) sdir_q[2'(sel[1:0] - 2'd1)] <= quot;
			else         tdir_q[2'(sel[1:0] - 2'd1)] <= quot;
		end
		if (cmd.op == OP_LAT_SUMS)
			sums_q <= {bit_rd, tan_rd};
		else if (cmd.op == OP_WRITE)
			sums_q <= '0;
	end
endmodule : tta_datapath
`default_nettype wire

>>> rtl/tta_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tta_ctrl
// Sequencer: accepts an item, steps the datapath, holds the result register.
// ----------------------------------------------------------------------------
module tta_ctrl #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [1:0]           action,
	input  wire [9:0]           idx_a,
	input  wire [9:0]           idx_b,
	input  wire [9:0]           idx_c,
	output tta_pkg::cmd_t       cmd,
	input  wire tta_pkg::sts_t  sts,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [1:0]          status,
	output logic                show_sums
);
	import tta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_B, S_RD_C, S_LAT_C, S_MUL, S_DET, S_CHK,
		S_NUM, S_DSTART, S_DWAIT, S_STORE, S_ACC_RD, S_ACC_WAIT, S_ACC_WR,
		S_SUMS, S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] dir_q;   // direction/component counter
	logic [1:0] crn_q;   // corner counter
	logic [1:0] act_q;

	function automatic logic in_range(input logic [9:0] i);
		return 32'(i) < VERTEX_DEPTH;
	endfunction

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd.op  = OP_NOP;
		cmd.sel = 3'd0;
		unique case (state_q)
			S_RD_B:     cmd.op = OP_RD_B;
			S_RD_C:     cmd.op = OP_RD_C;
			S_LAT_C:    cmd.op = OP_LAT_C;
			S_MUL:      cmd.op = OP_MUL;
			S_DET:      cmd.op = OP_DET;
			S_NUM:      begin cmd.op = OP_NUM; cmd.sel = dir_q; end
			S_DSTART:   cmd.op = OP_DIV_START;
			S_STORE:    begin
				cmd.op  = OP_STORE_Q;
				cmd.sel = {dir_q[2], 2'(dir_q[1:0] + 2'd1)};
			end
			S_ACC_RD:   begin cmd.op = OP_ACC_RD; cmd.sel = {1'b0, crn_q}; end
			S_ACC_WR:   begin cmd.op = OP_ACC_WR; cmd.sel = {1'b0, crn_q}; end
			S_SUMS:     cmd.op = OP_LAT_SUMS;
			S_ACC_WAIT: begin cmd.op = OP_NOP; cmd.sel = 3'd0; end
			default:    ;
		endcase
		if (state_q == S_IDLE && in_valid && in_ready) begin
			if (action == ACT_TRI && in_range(idx_a) && in_range(idx_b) && in_range(idx_c))
				cmd.op = OP_RD_A;
			else if (action == ACT_WRITE && in_range(idx_a))
				cmd.op = OP_WRITE;
			else if (action == ACT_READ && in_range(idx_a))
				cmd.op = OP_RD_SUMS;
		end
		// sum reads during ACC_WAIT need the corner address held
		if (state_q == S_ACC_WAIT) cmd.sel = {1'b0, crn_q};
	end

	assign show_sums = (act_q == ACT_READ) && (status == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			status    <= ST_OK;
			dir_q     <= '0;
			crn_q     <= '0;
			act_q     <= ACT_WRITE;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					act_q  <= action;
					status <= ST_OK;
					unique case (action)
						ACT_WRITE: begin
							if (!in_range(idx_a)) status <= ST_RANGE;
							out_valid <= 1'b1;
						end
						ACT_READ: begin
							if (!in_range(idx_a)) begin
								status    <= ST_RANGE;
								out_valid <= 1'b1;
							end else
								state_q <= S_SUMS;
						end
						ACT_TRI: begin
							if (!(in_range(idx_a) && in_range(idx_b) && in_range(idx_c))) begin
								status    <= ST_RANGE;
								out_valid <= 1'b1;
							end else
								state_q <= S_RD_B;
						end
						default: out_valid <= 1'b1;
					endcase
				end
				S_RD_B:  state_q <= S_RD_C;
				S_RD_C:  state_q <= S_LAT_C;
				S_LAT_C: state_q <= S_MUL;
				S_MUL:   state_q <= S_DET;
				S_DET:   state_q <= S_CHK;
				S_CHK: begin
					if (sts.det_zero) begin
						status    <= ST_DEGEN;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						dir_q   <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT:  if (!sts.div_busy) state_q <= S_STORE;
				S_STORE: begin
					if (dir_q == 3'd6) begin
						crn_q   <= '0;
						state_q <= S_ACC_RD;
					end else begin
						dir_q   <= (dir_q[1:0] == 2'd2) ? 3'd4 : 3'(dir_q + 3'd1);
						state_q <= S_NUM;
					end
				end
				S_ACC_RD:   state_q <= S_ACC_WAIT;
				S_ACC_WAIT: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (crn_q == 2'd2) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						crn_q   <= crn_q + 2'd1;
						state_q <= S_ACC_RD;
					end
				end
				S_SUMS: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule : tta_ctrl
`default_nettype wire

>>> rtl/triangle_tangent_accumulator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_accumulator_core
// Write, unused action, index out of range: out_valid is set at accept; read: via S_SUMS.
// Triangle: vertex reads, multiply, determinant and check, then six divisions, each
// with its numerator, start, wait and store states, then sum update of three corners.
// Degenerate triangle: result after the determinant check. One item at a time;
// the next is taken once the result has been taken.
// arst_n clears control only; vertex memories are undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_accumulator_core #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// action[1:0], first_index[11:2], second_index[21:12], third_index[31:22],
	// pos_x[63:32], pos_y[95:64], pos_z[127:96], tex_u[143:128], tex_v[159:144]
	input  wire [159:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// status[1:0], tangent_x[33:2], tangent_y[65:34], tangent_z[97:66],
	// bitangent_x[129:98], bitangent_y[161:130], bitangent_z[193:162], zero pad
	output logic [199:0] m_tdata
);
	import tta_pkg::*;

	cmd_t         cmd;
	sts_t         sts;
	logic [1:0]   status;
	logic         show_sums;
	logic [191:0] sums;

	tta_ctrl #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.action(s_tdata[1:0]), .idx_a(s_tdata[11:2]), .idx_b(s_tdata[21:12]),
		.idx_c(s_tdata[31:22]), .cmd(cmd), .sts(sts), .out_valid(m_tvalid),
		.out_ready(m_tready), .status(status), .show_sums(show_sums));

	// indices and payload are held by the upstream only at accept; latch them
	logic [159:0] item_q;
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_q <= s_tdata;
	end

	logic [159:0] item;
	assign item = (s_tvalid && s_tready) ? s_tdata : item_q;

	tta_datapath #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.idx_a(item[11:2]), .idx_b(item[21:12]), .idx_c(item[31:22]),
		.pos_x(item[63:32]), .pos_y(item[95:64]), .pos_z(item[127:96]),
		.tex_u(item[143:128]), .tex_v(item[159:144]), .sums(sums));

	assign m_tdata = {6'd0, (show_sums ? sums : 192'd0), status};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("accept while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != ST_UNUSED) else $error("bad status");
endmodule : triangle_tangent_accumulator_core
`default_nettype wire
